[rtl/core/dnsae_pkg.sv]
package dnsae_pkg;

  localparam logic [15:0] POINTER_WORD = 16'h0cc0;

  localparam logic [3:0] PH_HEADER       = 4'd0;
  localparam logic [3:0] PH_QNAME        = 4'd1;
  localparam logic [3:0] PH_QFIX         = 4'd2;
  localparam logic [3:0] PH_ANAME_FIRST  = 4'd3;
  localparam logic [3:0] PH_ANAME_SECOND = 4'd4;
  localparam logic [3:0] PH_ANAME_REST   = 4'd5;
  localparam logic [3:0] PH_AFIX         = 4'd6;
  localparam logic [3:0] PH_RDLEN        = 4'd7;
  localparam logic [3:0] PH_DATA         = 4'd8;
  localparam logic [3:0] PH_DRAIN        = 4'd9;

  localparam logic [1:0] KIND_ADDRESS   = 2'd0;
  localparam logic [1:0] KIND_OK        = 2'd1;
  localparam logic [1:0] KIND_ID_BAD    = 2'd2;
  localparam logic [1:0] KIND_TRUNCATED = 2'd3;

  localparam int HEADER_LAST = 11;
  localparam int QFIX_BYTES  = 4;
  localparam int AFIX_BYTES  = 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [15:0] data_length;
    logic        oversize;
    logic [15:0] response_flags;
    logic        last_result;
  } result_t;

endpackage

[rtl/core/dns_response_address_extractor_unit.sv]
// Parses a DNS response presented one byte per beat on the input channel and
// checks its transaction id against expected_id (first wire byte high). Every
// answer record gives one address beat; the byte flagged last_byte also gives
// a final status beat (ok, id mismatch or truncated), after any address beat
// from the same byte. A byte is parsed in the cycle it is accepted and its
// results go into a four-entry result queue, so one byte is taken every cycle
// while the queue has room for two results; in_stall rises only when the
// output side holds back and the queue fills. Bytes past MAX_PACKET_BYTES are
// counted out, not parsed. Write expected_id only between packets; unenforced.
module dns_response_address_extractor_unit
  import dnsae_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = 512
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [31:0] address,
  output logic [15:0] data_length,
  output logic        oversize,
  output logic [15:0] response_flags,
  output logic        last_result
);

  localparam int CountW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);

  logic [15:0]       expected_id;
  logic [3:0]        phase, phase_next;
  logic [3:0]        field_byte_count, field_byte_count_next;
  logic [15:0]       received_id, received_id_next;
  logic [15:0]       flags_word, flags_word_next;
  logic [15:0]       questions_left, questions_left_next;
  logic [15:0]       answers_left, answers_left_next;
  logic [15:0]       data_left, data_left_next;
  logic [15:0]       rd_length, rd_length_next;
  logic [31:0]       address_gather, address_gather_next;
  logic [2:0]        gathered, gathered_next;
  logic              answers_done, answers_done_next;
  logic              id_bad, id_bad_next;
  logic [CountW-1:0] byte_count, byte_count_next;

  logic              in_take, out_take;
  logic              fin;
  logic [3:0]        fbc_inc;
  logic [15:0]       q_dec, a_dec, d_dec;
  logic [1:0]        status_kind;
  result_t           addr_res, stat_res, res_a;
  logic [1:0]        wr_count;

  result_t           queue [QDepth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [PtrW:0]     q_count;

  assign in_take  = in_valid && !in_stall;
  assign out_valid = (q_count != '0);
  assign out_take = out_valid && !out_stall;
  assign in_stall = (q_count > (PtrW+1)'(QDepth - 2));

  assign fbc_inc = field_byte_count + 4'd1;
  assign q_dec   = questions_left - 16'd1;
  assign a_dec   = answers_left - 16'd1;
  assign d_dec   = data_left - 16'd1;

  // per-byte parse
  always_comb begin
    phase_next            = phase;
    field_byte_count_next = field_byte_count;
    received_id_next      = received_id;
    flags_word_next       = flags_word;
    questions_left_next   = questions_left;
    answers_left_next     = answers_left;
    data_left_next        = data_left;
    rd_length_next        = rd_length;
    address_gather_next   = address_gather;
    gathered_next         = gathered;
    answers_done_next     = answers_done;
    id_bad_next           = id_bad;
    byte_count_next       = byte_count;
    fin                   = 1'b0;

    if (byte_count < CountW'(MAX_PACKET_BYTES)) begin
      byte_count_next = byte_count + CountW'(1);
      case (phase)
        PH_HEADER: begin
          case (field_byte_count)
            4'd0: received_id_next = {data_byte, 8'h00};
            4'd1: received_id_next = {received_id[15:8], data_byte};
            4'd2: flags_word_next = {data_byte, 8'h00};
            4'd3: flags_word_next = {flags_word[15:8], data_byte};
            4'd4: questions_left_next = {data_byte, 8'h00};
            4'd5: questions_left_next = {questions_left[15:8], data_byte};
            4'd6: answers_left_next = {data_byte, 8'h00};
            4'd7: answers_left_next = {answers_left[15:8], data_byte};
            default: ;
          endcase
          field_byte_count_next = fbc_inc;
          if (field_byte_count == 4'd1 &&
              {received_id[15:8], data_byte} != expected_id) begin
            id_bad_next = 1'b1;
            phase_next  = PH_DRAIN;
          end else if (field_byte_count >= 4'(HEADER_LAST)) begin
            field_byte_count_next = '0;
            if (questions_left != '0) begin
              phase_next = PH_QNAME;
            end else if (answers_left != '0) begin
              phase_next = PH_ANAME_FIRST;
            end else begin
              answers_done_next = 1'b1;
              phase_next        = PH_DRAIN;
            end
          end
        end
        PH_QNAME: begin
          if (data_byte == 8'h00) begin
            phase_next            = PH_QFIX;
            field_byte_count_next = '0;
          end
        end
        PH_QFIX: begin
          field_byte_count_next = fbc_inc;
          if (fbc_inc >= 4'(QFIX_BYTES)) begin
            field_byte_count_next = '0;
            questions_left_next   = q_dec;
            if (q_dec != '0) begin
              phase_next = PH_QNAME;
            end else if (answers_left != '0) begin
              phase_next = PH_ANAME_FIRST;
            end else begin
              answers_done_next = 1'b1;
              phase_next        = PH_DRAIN;
            end
          end
        end
        PH_ANAME_FIRST: begin
          field_byte_count_next = '0;
          if (data_byte == 8'h00) begin
            phase_next = PH_AFIX;
          end else if (data_byte == POINTER_WORD[7:0]) begin
            phase_next = PH_ANAME_SECOND;
          end else begin
            phase_next = PH_ANAME_REST;
          end
        end
        PH_ANAME_SECOND: begin
          field_byte_count_next = '0;
          if (data_byte == POINTER_WORD[15:8] || data_byte == 8'h00) begin
            phase_next = PH_AFIX;
          end else begin
            phase_next = PH_ANAME_REST;
          end
        end
        PH_ANAME_REST: begin
          if (data_byte == 8'h00) begin
            phase_next            = PH_AFIX;
            field_byte_count_next = '0;
          end
        end
        PH_AFIX: begin
          field_byte_count_next = fbc_inc;
          if (fbc_inc >= 4'(AFIX_BYTES)) begin
            field_byte_count_next = '0;
            phase_next            = PH_RDLEN;
          end
        end
        PH_RDLEN: begin
          if (field_byte_count == '0) begin
            rd_length_next        = {data_byte, 8'h00};
            field_byte_count_next = 4'd1;
          end else begin
            rd_length_next        = {rd_length[15:8], data_byte};
            field_byte_count_next = '0;
            data_left_next        = {rd_length[15:8], data_byte};
            address_gather_next   = '0;
            gathered_next         = '0;
            if ({rd_length[15:8], data_byte} == 16'd0) begin
              fin = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          if (gathered < 3'd4) begin
            case (gathered[1:0])
              2'd0: address_gather_next[31:24] = data_byte;
              2'd1: address_gather_next[23:16] = data_byte;
              2'd2: address_gather_next[15:8]  = data_byte;
              default: address_gather_next[7:0] = data_byte;
            endcase
            gathered_next = gathered + 3'd1;
          end
          data_left_next = d_dec;
          if (d_dec == '0) begin
            fin = 1'b1;
          end
        end
        default: ;
      endcase

      if (fin) begin
        answers_left_next = a_dec;
        if (a_dec != '0) begin
          phase_next = PH_ANAME_FIRST;
        end else begin
          answers_done_next = 1'b1;
          phase_next        = PH_DRAIN;
        end
      end
    end
  end

  always_comb begin
    if (id_bad_next) begin
      status_kind = KIND_ID_BAD;
    end else if (answers_done_next) begin
      status_kind = KIND_OK;
    end else begin
      status_kind = KIND_TRUNCATED;
    end

    addr_res.kind           = KIND_ADDRESS;
    addr_res.address        = address_gather_next;
    addr_res.data_length    = rd_length_next;
    addr_res.oversize       = (rd_length_next > 16'd4);
    addr_res.response_flags = flags_word_next;
    addr_res.last_result    = !last_byte;

    stat_res.kind           = status_kind;
    stat_res.address        = '0;
    stat_res.data_length    = '0;
    stat_res.oversize       = 1'b0;
    stat_res.response_flags = flags_word_next;
    stat_res.last_result    = 1'b1;

    res_a    = fin ? addr_res : stat_res;
    wr_count = {1'b0, fin} + {1'b0, last_byte};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_id <= '0;
    end else if (cfg_wr_en) begin
      expected_id <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (in_take && last_byte)) begin
      phase            <= PH_HEADER;
      field_byte_count <= '0;
      received_id      <= '0;
      flags_word       <= '0;
      questions_left   <= '0;
      answers_left     <= '0;
      data_left        <= '0;
      rd_length        <= '0;
      address_gather   <= '0;
      gathered         <= '0;
      answers_done     <= 1'b0;
      id_bad           <= 1'b0;
      byte_count       <= '0;
    end else if (in_take) begin
      phase            <= phase_next;
      field_byte_count <= field_byte_count_next;
      received_id      <= received_id_next;
      flags_word       <= flags_word_next;
      questions_left   <= questions_left_next;
      answers_left     <= answers_left_next;
      data_left        <= data_left_next;
      rd_length        <= rd_length_next;
      address_gather   <= address_gather_next;
      gathered         <= gathered_next;
      answers_done     <= answers_done_next;
      id_bad           <= id_bad_next;
      byte_count       <= byte_count_next;
    end
  end

  // result queue
  always_ff @(posedge clk) begin
    if (in_take && wr_count != 2'd0) begin
      queue[wr_ptr] <= res_a;
      if (wr_count == 2'd2) begin
        queue[wr_ptr + PtrW'(1)] <= stat_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (in_take) begin
        wr_ptr <= wr_ptr + PtrW'(wr_count);
      end
      if (out_take) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      q_count <= q_count + (in_take ? (PtrW+1)'(wr_count) : '0)
                         - (out_take ? (PtrW+1)'(1) : '0);
    end
  end

  assign kind           = queue[rd_ptr].kind;
  assign address        = queue[rd_ptr].address;
  assign data_length    = queue[rd_ptr].data_length;
  assign oversize       = queue[rd_ptr].oversize;
  assign response_flags = queue[rd_ptr].response_flags;
  assign last_result    = queue[rd_ptr].last_result;

endmodule
